>>> hw/rtl/udiv_pkg.sv
// Shared types for the unsigned divider.
// No dependencies; imported by the sequencer, the datapath and the top level.
`default_nettype none

package udiv_pkg;

  // Per-cycle control from the sequencer to the shift-subtract datapath.
  typedef struct packed {
    logic load;  // capture a new item's operands
    logic step;  // run one restoring shift-subtract step
  } udiv_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/udiv_sequencer.sv
// Step sequencer for the unsigned divider: busy flag, step counter, done strobe.
// Depends on udiv_pkg.
`default_nettype none

module udiv_sequencer #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  output logic                 done,
  output udiv_pkg::udiv_ctrl_t ctrl
);
  import udiv_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  logic [CNT_W-1:0] count;
  logic             accept;
  logic             last;

  assign accept    = start && !busy;
  assign last      = busy && (count == CNT_W'(1));
  assign ctrl.load = accept;
  assign ctrl.step = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= last;
      if (accept) begin
        busy  <= 1'b1;
        count <= CNT_W'(DATA_WIDTH);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/udiv_datapath.sv
// Restoring radix-2 divide datapath: one shared subtractor, one quotient bit per step.
// Depends on udiv_pkg.
`default_nettype none

module udiv_datapath #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                   clk,
  input  udiv_pkg::udiv_ctrl_t  ctrl,
  input  wire  [DATA_WIDTH-1:0] dividend,
  input  wire  [DATA_WIDTH-1:0] divisor,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder,
  output logic                  divide_by_zero
);
  import udiv_pkg::*;

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] den;
  logic                  dz;

  logic [DATA_WIDTH:0]   partial;
  logic [DATA_WIDTH:0]   diff;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder, trial subtract.
  assign partial = {rem, quo[DATA_WIDTH-1]};
  assign diff    = partial - {1'b0, den};
  assign fits    = (partial >= {1'b0, den});

  // A zero divisor always fits: quotient ends all ones, remainder = dividend.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
      dz  <= (divisor == '0);
    end else if (ctrl.step) begin
      rem <= fits ? diff[DATA_WIDTH-1:0] : partial[DATA_WIDTH-1:0];
      quo <= {quo[DATA_WIDTH-2:0], fits};
    end
  end

  assign quotient       = quo;
  assign remainder      = rem;
  assign divide_by_zero = dz;

endmodule

`default_nettype wire

>>> hw/rtl/unsigned_divide_with_remainder_core.sv
// Top level of the iterative unsigned divider with remainder.
// Depends on udiv_pkg, udiv_sequencer and udiv_datapath.
`default_nettype none

// Unsigned DATA_WIDTH-bit divider. Raise start with dividend and divisor
// valid; the item is taken at the clock edge where start is high and busy
// is low, and busy then stays high while the item is worked on. One
// restoring shift-subtract step runs per cycle on a single shared
// subtractor, so an item needs DATA_WIDTH steps: done pulses for one cycle
// once the last step has run, and the next item can be taken in that same
// done cycle. quotient, remainder and divide_by_zero are valid only while
// done is high and the receiver must take them then; there is no
// back-pressure. A zero divisor sets divide_by_zero, returns an all-ones
// quotient and passes the dividend through as remainder.
module unsigned_divide_with_remainder_core #(
  parameter int DATA_WIDTH = 64
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire  [DATA_WIDTH-1:0] dividend,
  input  wire  [DATA_WIDTH-1:0] divisor,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] quotient,
  output logic [DATA_WIDTH-1:0] remainder,
  output logic                  divide_by_zero
);
  import udiv_pkg::*;

  udiv_ctrl_t ctrl;

  // Sequencer: accepts items, counts steps, strobes done.
  udiv_sequencer #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctrl  (ctrl)
  );

  // Datapath: partial remainder, quotient shifter and divisor register.
  udiv_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .ctrl           (ctrl),
    .dividend       (dividend),
    .divisor        (divisor),
    .quotient       (quotient),
    .remainder      (remainder),
    .divide_by_zero (divide_by_zero)
  );

  // done only ever follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a preceding busy cycle");

  // an accepted item starts the step sequence
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("accepted item did not start the sequence");

  // zero divisor yields an all-ones quotient
  a_dz_quotient: assert property (@(posedge clk) disable iff (rst)
    (done && divide_by_zero) |-> (quotient == '1))
    else $error("zero divisor without all-ones quotient");

endmodule

`default_nettype wire

>>> tb/sv/unsigned_divide_with_remainder_core_tb.sv
// Self-checking testbench for unsigned_divide_with_remainder_core.
// Depends only on the RTL of the divider. It predicts each quotient, remainder and
// divide-by-zero flag, and checks them against the done strobe.
`default_nettype none

module unsigned_divide_with_remainder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH   = 64;
  localparam int RESET_CYCLES = 12;
  localparam int RANDOM_ITEMS = 680;  // random part, idle bursts included
  localparam int QUIET_ITEMS  = 120;  // tail of the random part, sender never idles
  localparam int DRAIN_LIMIT  = 4 * DATA_WIDTH;
  // A slow correct run of ~730 items on the 4 ns clock takes about 200 us.
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
  } div_result_t;

  logic  clk   = 1'b0;
  logic  rst   = 1'b1;
  logic  start = 1'b0;
  word_t dividend = '0;
  word_t divisor  = '0;

  logic  busy;
  logic  done;
  word_t quotient;
  word_t remainder;
  logic  divide_by_zero;

  // Quotient/remainder sets waiting for their done strobe, oldest first.
  div_result_t pending_results[$];
  int          mismatch_count = 0;

  unsigned_divide_with_remainder_core #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .dividend      (dividend),
    .divisor       (divisor),
    .done          (done),
    .quotient      (quotient),
    .remainder     (remainder),
    .divide_by_zero(divide_by_zero)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: exact unsigned division. A zero divisor raises the flag, returns
  // an all-ones quotient and hands the dividend back as the remainder.
  // ---------------------------------------------------------------------------
  function automatic div_result_t divide_expected(word_t num, word_t den);
    div_result_t r;
    if (den == '0) begin
      r.quotient       = '1;
      r.remainder      = num;
      r.divide_by_zero = 1'b1;
    end else begin
      r.quotient       = num / den;
      r.remainder      = num % den;
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  // Full-width random word; the 64-bit concatenation is cast to DATA_WIDTH.
  function automatic word_t random_word();
    return word_t'({$urandom(), $urandom()});
  endfunction

  // Operand with a mix of shapes: full width, random bit length, a single
  // 16-bit digit, zero, all ones and single powers of two.
  function automatic word_t random_operand();
    case ($urandom_range(0, 7))
      0, 1:    return random_word();
      2, 3:    return random_word() >> $urandom_range(1, DATA_WIDTH - 1);
      4:       return word_t'($urandom_range(0, 16'hffff));
      5:       return '0;
      6:       return '1;
      default: return word_t'(1) << $urandom_range(0, DATA_WIDTH - 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a rising edge; drives the item and holds it until the
  // edge where busy is low, which is the accepting edge. start stays high on
  // return so a following item goes out back to back; idling lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_item(word_t num, word_t den);
    start    <= 1'b1;
    dividend <= num;
    divisor  <= den;
    do @(posedge clk); while (busy);
    pending_results.push_back(divide_expected(num, den));
  endtask

  task automatic pause_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random idle burst on about a third of the items.
  task automatic maybe_idle();
    if ($urandom_range(0, 2) == 0)
      pause_sender($urandom_range(1, 4));
  endtask

  // Hold the sender off until every outstanding result is back.
  task automatic wait_for_drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. The receiver has no back-pressure: each done cycle carries
  // one result, matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic report_field(string field, word_t want, word_t got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $realtime, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    div_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, quotient %h remainder %h flag %b",
                 $realtime, quotient, remainder, divide_by_zero);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("quotient", want.quotient, quotient);
        report_field("remainder", want.remainder, remainder);
        report_field("divide_by_zero", word_t'(want.divide_by_zero), word_t'(divide_by_zero));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Operand extremes and the named corner cases, with random idle bursts in between.
  task automatic test_directed();
    word_t top_bit;
    top_bit = word_t'(1) << (DATA_WIDTH - 1);
    send_item('0, '0);                  // zero divisor, zero dividend
    send_item('1, '0);                  // zero divisor, all-ones dividend
    send_item(word_t'(12345), '0);      // zero divisor, ordinary dividend
    send_item('1, word_t'(1));          // divide by one
    send_item('1, '1);                  // equal operands, both all ones
    send_item('0, '1);                  // zero over largest
    send_item(word_t'(1), '1);          // dividend below divisor
    send_item('1 - word_t'(1), '1);     // dividend just below divisor
    maybe_idle();
    send_item(top_bit, word_t'(2));
    send_item(top_bit, top_bit + word_t'(1));
    send_item('1, word_t'(16'hffff));   // largest single-digit divisor
    send_item('1, word_t'(17'h10000));  // smallest two-digit divisor
    send_item('1, word_t'(3));
    send_item(word_t'(100), word_t'(7));
    send_item(word_t'(7), word_t'(100));
    maybe_idle();
    send_item(top_bit, top_bit);
    send_item('1, top_bit);
    send_item(word_t'(1), word_t'(1));
    send_item('1 >> 1, '1 >> (DATA_WIDTH / 2));
  endtask

  // Items taken in the done cycle of the previous item, no gaps at all.
  task automatic test_back_to_back();
    repeat (20) send_item(random_operand(), random_operand());
  endtask

  // Four zero-divisor items, then the sender waits until all are back and sends one more.
  task automatic test_zero_divisor_with_drain();
    repeat (4) send_item(random_word(), '0);
    wait_for_drain();
    send_item(random_word(), '0);
  endtask

  // Random operands; the divisor is often tied to the dividend so the
  // quotient lands near 0, 1 or a power of two, not just anywhere.
  task automatic test_random(int count, bit with_idle);
    word_t num;
    word_t den;
    for (int i = 0; i < count; i++) begin
      num = random_operand();
      case ($urandom_range(0, 9))
        0:       den = num;
        1:       den = num + word_t'(1);
        2:       den = num - word_t'($urandom_range(0, 3));
        3:       den = num >> $urandom_range(1, DATA_WIDTH - 1);
        default: den = random_operand();
      endcase
      send_item(num, den);
      if (with_idle)
        maybe_idle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_back_to_back();
    test_zero_divisor_with_drain();
    test_random(RANDOM_ITEMS - QUIET_ITEMS, 1'b1);
    test_random(QUIET_ITEMS, 1'b0);

    // Drain with a bound, then watch a full item time for stray strobes.
    start <= 1'b0;
    for (int i = 0; i < DRAIN_LIMIT && pending_results.size() != 0; i++)
      @(posedge clk);
    repeat (DATA_WIDTH + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $realtime, pending_results.size());
      mismatch_count += pending_results.size();
    end

    if (mismatch_count == 0) begin
      $display("PASS unsigned_divide_with_remainder_core");
    end else begin
      $display("FAIL unsigned_divide_with_remainder_core");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #TIMEOUT_NS;
    $display("FAIL unsigned_divide_with_remainder_core");
    $finish;
  end

endmodule

`default_nettype wire
